FILE: rtl/snd_pkg.sv
// shared types and constants for the int8 scatter-nd store
package snd_pkg;

  localparam int NDIMS    = 5;
  localparam int CMD_W    = 2;
  localparam int COORD_W  = 12;
  localparam int DIM_W    = 13;
  localparam int RANK_W   = 3;
  localparam int REG_W    = 3;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;

  // register indexes on the configuration channel
  localparam logic [REG_W-1:0] REG_DIM0  = 3'd0;
  localparam logic [REG_W-1:0] REG_DIM1  = 3'd1;
  localparam logic [REG_W-1:0] REG_DIM2  = 3'd2;
  localparam logic [REG_W-1:0] REG_DIM3  = 3'd3;
  localparam logic [REG_W-1:0] REG_DIM4  = 3'd4;
  localparam logic [REG_W-1:0] REG_RANK  = 3'd5;
  localparam logic [REG_W-1:0] REG_DEPTH = 3'd6;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_SCATTER = 2'd1,
    CMD_READ    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_DEPTH = 2'd1,
    ST_RANGE     = 2'd2
  } status_e;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic [COORD_W-1:0]        flat_address;
    logic signed [BYTE_W-1:0]  data_byte;
    logic [COORD_W-1:0]        coord0;
    logic [COORD_W-1:0]        coord1;
    logic [COORD_W-1:0]        coord2;
    logic [COORD_W-1:0]        coord3;
    logic [COORD_W-1:0]        coord4;
    logic [COORD_W-1:0]        slice_offset;
  } item_t;

  typedef struct packed {
    logic signed [BYTE_W-1:0] read_byte;
    logic [STATUS_W-1:0]      status;
  } result_t;

  // geometry status handed from the stride engine to the datapath
  typedef struct packed {
    logic              busy;
    logic [RANK_W-1:0] eff_rank;
    logic [RANK_W-1:0] index_depth;
  } geom_t;

endpackage

FILE: rtl/snd_if.sv
// valid/ready channel interfaces for items, results and configuration writes
interface snd_item_if;
  import snd_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface snd_result_if;
  import snd_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface snd_cfg_if;
  import snd_pkg::*;
  logic             valid;
  logic             ready;
  logic [REG_W-1:0] reg_index;
  logic [DIM_W-1:0] wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: rtl/scatter_nd_int8_overwrite_core.sv
// top level of the int8 scatter-nd overwrite store
//
// Channels: item_i takes load, scatter and read commands; result_o returns
// one result (read byte, status) per item in order; cfg_i writes the five
// dimension sizes, the tensor rank and the index depth.
// Each item runs through input register, product stage, partial sum stage,
// address/range stage and the store access into the output register. One
// item per cycle is sustained; apart from configuration, the only stall on
// the item side comes from the result side.
// Every configuration transfer restarts the stride engine, which walks the
// five dimensions with one shared multiplier, one per cycle: item_i.ready
// stays low after the last configuration write until the walk is done.
// Reset sets all sizes, rank and depth to one; the byte store itself is not
// cleared and has to be loaded before it is read.
// When result_o is stalled the pipeline stages fill up behind the output
// register, and item_i.ready falls only once every stage holds an item.
module scatter_nd_int8_overwrite_core #(
  parameter int STORE_DEPTH = 4096,
  parameter int MAX_RANK    = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  snd_item_if.sink      item_i,
  snd_result_if.source  result_o,
  snd_cfg_if.sink       cfg_i
);
  import snd_pkg::*;

  localparam int SW = $clog2(STORE_DEPTH + 1);
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int PW = COORD_W + SW;
  localparam int XW = SW + 2;

  logic [SW-1:0] stride [NDIMS];
  logic [SW-1:0] limit;
  geom_t         geom;

  snd_geom #(
    .STORE_DEPTH (STORE_DEPTH),
    .MAX_RANK    (MAX_RANK)
  ) u_geom (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .stride_o (stride),
    .limit_o  (limit),
    .geom_o   (geom)
  );

  // stage valid bits and load enables
  logic v0_q, v1_q, v2_q, v3_q, out_v_q;
  logic en0, en1, en2, en3, en_out;

  assign en_out = !out_v_q || result_o.ready;
  assign en3    = !v3_q || en_out;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;
  assign en0    = !v0_q || en1;

  assign item_i.ready = en0 && !geom.busy;

  // stage 0: input register
  item_t it0_q;

  // stage 1: clipped products
  logic [CMD_W-1:0]   cmd1_q;
  logic [COORD_W-1:0] flat1_q;
  logic [BYTE_W-1:0]  byte1_q;
  logic [SW-1:0]      prod1_q [NDIMS];
  logic [SW-1:0]      off1_q;
  logic               bad1_q;
  logic [SW-1:0]      prod1_d [NDIMS];
  logic [SW-1:0]      off1_d;
  logic               bad1_d;
  logic [COORD_W-1:0] coord [NDIMS];
  logic [PW-1:0]      prod_full [NDIMS];

  // stage 2: partial sums
  logic [CMD_W-1:0]   cmd2_q;
  logic [COORD_W-1:0] flat2_q;
  logic [BYTE_W-1:0]  byte2_q;
  logic [SW:0]        sum01_q, sum23_q, sum4o_q;
  logic               bad2_q;

  // stage 3: address and status
  logic [AW-1:0]       addr3_q, addr3_d;
  logic [BYTE_W-1:0]   byte3_q;
  logic [STATUS_W-1:0] st3_q, st3_d;
  logic                wr3_q, wr3_d, rd3_q, rd3_d;
  logic [XW-1:0]       addr_sum;
  logic [31:0]         target;
  logic                in_range;

  // output register
  logic [STATUS_W-1:0] out_st_q;
  logic                out_rd_q;
  logic [BYTE_W-1:0]   ram_rdata;
  logic                ram_we, ram_re;

  assign coord[0] = it0_q.coord0;
  assign coord[1] = it0_q.coord1;
  assign coord[2] = it0_q.coord2;
  assign coord[3] = it0_q.coord3;
  assign coord[4] = it0_q.coord4;

  // coordinate times stride, clipped at the store depth, masked past the depth
  always_comb begin
    for (int i = 0; i < NDIMS; i++) begin
      prod_full[i] = PW'(coord[i]) * PW'(stride[i]);
      if (RANK_W'(i) >= geom.index_depth) begin
        prod1_d[i] = '0;
      end else if (64'(prod_full[i]) >= 64'(STORE_DEPTH)) begin
        prod1_d[i] = SW'(STORE_DEPTH);
      end else begin
        prod1_d[i] = SW'(prod_full[i]);
      end
    end
    off1_d = (32'(it0_q.slice_offset) >= 32'(STORE_DEPTH)) ? SW'(STORE_DEPTH)
                                                           : SW'(it0_q.slice_offset);
    bad1_d = (geom.index_depth == '0) || (geom.index_depth > geom.eff_rank);
  end

  // final address, range check and status
  always_comb begin
    addr_sum = XW'(sum01_q) + XW'(sum23_q) + XW'(sum4o_q);
    target   = (cmd2_q == CMD_SCATTER) ? 32'(addr_sum) : 32'(flat2_q);
    in_range = target < 32'(limit);
    addr3_d  = AW'(target);
    st3_d    = ST_OK;
    wr3_d    = 1'b0;
    rd3_d    = 1'b0;
    case (cmd2_q)
      CMD_LOAD: begin
        wr3_d = in_range;
        if (!in_range) st3_d = ST_RANGE;
      end
      CMD_SCATTER: begin
        if (bad2_q) begin
          st3_d = ST_BAD_DEPTH;
        end else if (!in_range) begin
          st3_d = ST_RANGE;
        end else begin
          wr3_d = 1'b1;
        end
      end
      CMD_READ: begin
        rd3_d = in_range;
        if (!in_range) st3_d = ST_RANGE;
      end
      default: ;
    endcase
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en0)    v0_q    <= item_i.valid && item_i.ready;
      if (en1)    v1_q    <= v0_q;
      if (en2)    v2_q    <= v1_q;
      if (en3)    v3_q    <= v2_q;
      if (en_out) out_v_q <= v3_q;
    end
  end

  // stage payload registers
  always_ff @(posedge clk_i) begin
    if (en0) begin
      it0_q <= item_i.data;
    end
    if (en1) begin
      cmd1_q  <= it0_q.cmd;
      flat1_q <= it0_q.flat_address;
      byte1_q <= it0_q.data_byte;
      prod1_q <= prod1_d;
      off1_q  <= off1_d;
      bad1_q  <= bad1_d;
    end
    if (en2) begin
      cmd2_q  <= cmd1_q;
      flat2_q <= flat1_q;
      byte2_q <= byte1_q;
      sum01_q <= (SW+1)'(prod1_q[0]) + (SW+1)'(prod1_q[1]);
      sum23_q <= (SW+1)'(prod1_q[2]) + (SW+1)'(prod1_q[3]);
      sum4o_q <= (SW+1)'(prod1_q[4]) + (SW+1)'(off1_q);
      bad2_q  <= bad1_q;
    end
    if (en3) begin
      addr3_q <= addr3_d;
      byte3_q <= byte2_q;
      st3_q   <= st3_d;
      wr3_q   <= wr3_d;
      rd3_q   <= rd3_d;
    end
    if (en_out) begin
      out_st_q <= st3_q;
      out_rd_q <= v3_q && rd3_q;
    end
  end

  // byte store, accessed as an item moves into the output register
  assign ram_we = en_out && v3_q && wr3_q;
  assign ram_re = en_out && v3_q && rd3_q;

  snd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr3_q),
    .wdata_i (byte3_q),
    .re_i    (ram_re),
    .raddr_i (addr3_q),
    .rdata_o (ram_rdata)
  );

  assign result_o.valid          = out_v_q;
  assign result_o.data.read_byte = out_rd_q ? ram_rdata : '0;
  assign result_o.data.status    = out_st_q;

  // a store access is either a write or a read, never both
  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("store written and read in the same cycle");

  // a store read always lands in the output register as a read result
  a_read_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> out_v_q && out_rd_q && (out_st_q == ST_OK))
    else $error("store read without matching read result");

  // a failed item never returns store data
  a_fail_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (out_st_q != ST_OK) |-> !out_rd_q)
    else $error("failed item carries read data");

endmodule

FILE: rtl/snd_ram.sv
// generic single-write, single-read ram with registered read data
module snd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/snd_geom.sv
// configuration registers and sequential stride / tensor total engine
module snd_geom #(
  parameter int STORE_DEPTH = 4096,
  parameter int MAX_RANK    = 5,
  localparam int SW         = $clog2(STORE_DEPTH + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  snd_cfg_if.sink        cfg_i,
  output logic [SW-1:0]  stride_o [snd_pkg::NDIMS],
  output logic [SW-1:0]  limit_o,
  output snd_pkg::geom_t geom_o
);
  import snd_pkg::*;

  localparam int RCAP = (MAX_RANK < NDIMS) ? MAX_RANK : NDIMS;
  localparam int MW   = SW + DIM_W;

  logic [DIM_W-1:0]  dim_q [NDIMS];
  logic [RANK_W-1:0] rank_q, depth_q, eff_rank;
  logic              busy_q;
  logic [2:0]        step_q;
  logic [SW-1:0]     run_q, run_d;
  logic [SW-1:0]     stride_q [NDIMS];
  logic [SW-1:0]     limit_q;
  logic [DIM_W-1:0]  eff_size;
  logic [MW-1:0]     prod;
  logic              cfg_wr;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;

  // rank capped at the supported number of dimensions
  assign eff_rank = (rank_q > RANK_W'(RCAP)) ? RANK_W'(RCAP) : rank_q;

  // one saturating multiply per cycle, from the innermost dimension outward
  always_comb begin
    eff_size = (step_q < eff_rank) ? dim_q[step_q] : DIM_W'(1);
    prod     = MW'(run_q) * MW'(eff_size);
    run_d    = (64'(prod) >= 64'(STORE_DEPTH)) ? SW'(STORE_DEPTH) : SW'(prod);
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NDIMS; i++) dim_q[i] <= DIM_W'(1);
      rank_q  <= RANK_W'(1);
      depth_q <= RANK_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_i.reg_index)
        REG_DIM0:  dim_q[0] <= cfg_i.wdata;
        REG_DIM1:  dim_q[1] <= cfg_i.wdata;
        REG_DIM2:  dim_q[2] <= cfg_i.wdata;
        REG_DIM3:  dim_q[3] <= cfg_i.wdata;
        REG_DIM4:  dim_q[4] <= cfg_i.wdata;
        REG_RANK:  rank_q   <= cfg_i.wdata[RANK_W-1:0];
        REG_DEPTH: depth_q  <= cfg_i.wdata[RANK_W-1:0];
        default: ;
      endcase
    end
  end

  // stride sequencer, restarted by every configuration transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      step_q  <= 3'(NDIMS - 1);
      run_q   <= SW'(1);
      limit_q <= SW'(1);
      for (int i = 0; i < NDIMS; i++) stride_q[i] <= SW'(1);
    end else if (cfg_wr) begin
      busy_q <= 1'b1;
      step_q <= 3'(NDIMS - 1);
      run_q  <= SW'(1);
    end else if (busy_q) begin
      stride_q[step_q] <= run_q;
      run_q            <= run_d;
      if (step_q == 3'd0) begin
        busy_q  <= 1'b0;
        limit_q <= run_d;
      end else begin
        step_q <= step_q - 3'd1;
      end
    end
  end

  assign stride_o = stride_q;
  assign limit_o  = limit_q;
  assign geom_o   = '{busy: busy_q, eff_rank: eff_rank, index_depth: depth_q};

endmodule

FILE: tb/sv/tb_scatter_nd_int8_overwrite_core.sv
`timescale 1ns / 1ps
// self-checking testbench for the int8 scatter-nd overwrite store
module tb_scatter_nd_int8_overwrite_core;
  import snd_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int STORE_DEPTH = 4096;
  localparam int MAX_RANK    = 5;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 68;
  localparam int CYCLE_LIMIT = 200000;
  localparam longint unsigned SAT_LIMIT = 64'd1 << 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  snd_item_if   item_ch ();
  snd_result_if result_ch ();
  snd_cfg_if    cfg_ch ();

  scatter_nd_int8_overwrite_core #(
    .STORE_DEPTH(STORE_DEPTH),
    .MAX_RANK   (MAX_RANK)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_ch),
    .result_o(result_ch),
    .cfg_i   (cfg_ch)
  );

  // shadow of the geometry registers, reset values
  logic [DIM_W-1:0]  dim_reg [NDIMS] = '{1, 1, 1, 1, 1};
  logic [RANK_W-1:0] rank_reg  = 1;
  logic [RANK_W-1:0] depth_reg = 1;
  longint unsigned   geo_stride [NDIMS];

  // predicted tensor contents and which bytes the stimulus has already written
  logic signed [BYTE_W-1:0] tensor_image [STORE_DEPTH];
  bit                       written_map [STORE_DEPTH];
  logic [COORD_W-1:0]       written_list [$];

  item_t   cmd_backlog [$];
  result_t awaited_replies [$];
  int      mismatch_count = 0;
  int      cycle_count;
  bit      item_fire = 1'b0;
  int      burst_left = 1;
  int      gap_left = 0;
  logic [7:0] stall_mask = 8'hFF;
  logic [5:0] stall_tick = '0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int eff_rank();
    return (rank_reg > MAX_RANK) ? MAX_RANK : int'(rank_reg);
  endfunction

  // row-major strides into geo_stride, returns the tensor total, both saturated
  function automatic longint unsigned tensor_geometry();
    longint unsigned running;
    longint unsigned size;
    int d;
    running = 1;
    for (d = NDIMS - 1; d >= 0; d--) begin
      size = (d < eff_rank()) ? longint'(dim_reg[d]) : 1;
      geo_stride[d] = running;
      if (size == 0) begin
        running = 0;
      end else if (running >= SAT_LIMIT) begin
        running = SAT_LIMIT;
      end else begin
        running = running * size;
        if (running >= SAT_LIMIT) running = SAT_LIMIT;
      end
    end
    return running;
  endfunction

  // target element of a command and its status under the current geometry
  function automatic status_e element_address(input item_t it,
                                              output logic [COORD_W-1:0] addr);
    logic [COORD_W-1:0] coord [NDIMS];
    longint unsigned limit;
    longint unsigned sum;
    int k;
    limit = tensor_geometry();
    if (limit > STORE_DEPTH) limit = STORE_DEPTH;
    addr = it.flat_address;
    if (it.cmd != CMD_SCATTER) return (it.flat_address < limit) ? ST_OK : ST_RANGE;
    // depth is checked before the address
    if (depth_reg == 0 || depth_reg > eff_rank()) return ST_BAD_DEPTH;
    coord[0] = it.coord0;
    coord[1] = it.coord1;
    coord[2] = it.coord2;
    coord[3] = it.coord3;
    coord[4] = it.coord4;
    sum = it.slice_offset;
    for (k = 0; k < depth_reg; k++) sum += coord[k] * geo_stride[k];
    if (sum >= limit) return ST_RANGE;
    addr = sum[COORD_W-1:0];
    return ST_OK;
  endfunction

  function automatic item_t random_item(input cmd_e c);
    item_t it;
    it.cmd          = c;
    it.flat_address = COORD_W'($urandom_range(0, 4095));
    it.data_byte    = BYTE_W'($urandom_range(0, 255));
    it.coord0       = COORD_W'($urandom_range(0, 4095));
    it.coord1       = COORD_W'($urandom_range(0, 4095));
    it.coord2       = COORD_W'($urandom_range(0, 4095));
    it.coord3       = COORD_W'($urandom_range(0, 4095));
    it.coord4       = COORD_W'($urandom_range(0, 4095));
    it.slice_offset = COORD_W'($urandom_range(0, 4095));
    return it;
  endfunction

  function automatic item_t flat_item(input cmd_e c, input int flat, input int data);
    item_t it;
    it = random_item(c);
    it.flat_address = COORD_W'(flat);
    it.data_byte    = BYTE_W'(data);
    return it;
  endfunction

  function automatic item_t scatter_item(input int c0, input int c1, input int c2,
                                         input int c3, input int c4, input int off,
                                         input int data);
    item_t it;
    it = random_item(CMD_SCATTER);
    it.coord0       = COORD_W'(c0);
    it.coord1       = COORD_W'(c1);
    it.coord2       = COORD_W'(c2);
    it.coord3       = COORD_W'(c3);
    it.coord4       = COORD_W'(c4);
    it.slice_offset = COORD_W'(off);
    it.data_byte    = BYTE_W'(data);
    return it;
  endfunction

  // coordinate inside its dimension, zero on a coin flip where the stride reaches the store depth
  function automatic logic [COORD_W-1:0] shaped_coord(input int d);
    int hi;
    hi = (d < eff_rank()) ? int'(dim_reg[d]) : 1;
    if (hi == 0) return COORD_W'($urandom_range(0, 4095));
    if (geo_stride[d] >= STORE_DEPTH && $urandom_range(0, 1) == 1) return '0;
    return COORD_W'($urandom_range(0, (hi > STORE_DEPTH ? STORE_DEPTH : hi) - 1));
  endfunction

  // an in-range read of a never-written byte is turned into a load
  task automatic queue_item(input item_t it);
    logic [COORD_W-1:0] addr;
    status_e st;
    st = element_address(it, addr);
    if (it.cmd == CMD_READ && st == ST_OK && !written_map[addr]) it.cmd = CMD_LOAD;
    if ((it.cmd == CMD_LOAD || it.cmd == CMD_SCATTER) && st == ST_OK && !written_map[addr]) begin
      written_map[addr] = 1'b1;
      written_list.push_back(addr);
    end
    cmd_backlog.push_back(it);
  endtask

  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || item_ch.valid || awaited_replies.size() != 0)
      @(posedge clk_i);
  endtask

  // one register write, only with the block drained
  task automatic write_reg(input logic [REG_W-1:0] idx, input int value);
    wait_idle();
    @(negedge clk_i);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= DIM_W'(value);
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    case (idx)
      REG_RANK:  rank_reg = RANK_W'(value);
      REG_DEPTH: depth_reg = RANK_W'(value);
      default:   dim_reg[idx] = DIM_W'(value);
    endcase
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_geometry(input int d0, input int d1, input int d2, input int d3,
                              input int d4, input int rank, input int depth);
    write_reg(REG_DIM0, d0);
    write_reg(REG_DIM1, d1);
    write_reg(REG_DIM2, d2);
    write_reg(REG_DIM3, d3);
    write_reg(REG_DIM4, d4);
    write_reg(REG_RANK, rank);
    write_reg(REG_DEPTH, depth);
  endtask

  // item driver: bursts of transfers with random gaps between them
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      item_ch.valid <= 1'b0;
    end else if (!item_ch.valid || item_fire) begin
      if (gap_left != 0 || cmd_backlog.size() == 0) begin
        item_ch.valid <= 1'b0;
        if (gap_left != 0) gap_left--;
      end else begin
        item_ch.data  <= cmd_backlog.pop_front();
        item_ch.valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // result receiver stalls on a rotating mask, refreshed each time the tick counter wraps
  always @(negedge clk_i) begin
    if (stall_tick == 0)
      stall_mask = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
    result_ch.ready <= rst_ni && stall_mask[stall_tick[2:0]];
    stall_tick = stall_tick + 1'b1;
  end

  // monitor: predict on each item transfer, check each result transfer
  always @(posedge clk_i) begin
    item_t   it;
    result_t want;
    result_t got;
    status_e st;
    logic [COORD_W-1:0] addr;
    item_fire = rst_ni && item_ch.valid && item_ch.ready;
    if (item_fire) begin
      it   = item_ch.data;
      want = '0;
      if (it.cmd != CMD_NONE) begin
        st = element_address(it, addr);
        want.status = st;
        if (st == ST_OK) begin
          if (it.cmd == CMD_READ) want.read_byte = tensor_image[addr];
          else tensor_image[addr] = it.data_byte;
        end
      end
      awaited_replies.push_back(want);
    end
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      got = result_ch.data;
      if (awaited_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: read_byte=%0d status=%0d", got.read_byte, got.status);
      end else begin
        want = awaited_replies.pop_front();
        if (got.read_byte !== want.read_byte || got.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected read_byte=%0d status=%0d, got read_byte=%0d status=%0d",
                     want.read_byte, want.status, got.read_byte, got.status);
        end
      end
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // stimulus
  initial begin
    item_t it;
    int phase;
    int n;
    int i;
    int pick;
    int rank_pick;
    int depth_pick;
    int span;
    int dims_pick [NDIMS];
    longint unsigned limit;

    item_ch.valid    = 1'b0;
    item_ch.data     = '0;
    result_ch.ready  = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = '0;
    cfg_ch.wdata     = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset geometry: a one-element tensor
    queue_item(flat_item(CMD_READ, 5, 0));
    queue_item(flat_item(CMD_LOAD, 0, -128));
    queue_item(flat_item(CMD_READ, 0, 0));
    queue_item(scatter_item(0, 4095, 4095, 4095, 4095, 0, 127));
    queue_item(flat_item(CMD_READ, 0, 0));
    queue_item(scatter_item(4095, 0, 0, 0, 0, 0, 1));
    queue_item(flat_item(CMD_LOAD, 4095, 127));
    queue_item(flat_item(CMD_NONE, 4095, -1));

    // rank five, two index dimensions: last element, overrun, overwrite
    set_geometry(4, 3, 2, 2, 2, 5, 2);
    queue_item(scatter_item(3, 2, 0, 0, 0, 7, 85));
    queue_item(flat_item(CMD_READ, 95, 0));
    queue_item(scatter_item(3, 2, 0, 0, 0, 8, 1));
    queue_item(scatter_item(0, 0, 0, 0, 0, 4095, 1));
    queue_item(scatter_item(0, 0, 0, 0, 0, 95, -7));
    queue_item(flat_item(CMD_READ, 95, 0));

    // bad depth wins over a bad address
    write_reg(REG_DEPTH, 0);
    queue_item(scatter_item(4095, 4095, 4095, 4095, 4095, 4095, 3));
    write_reg(REG_DEPTH, 6);
    queue_item(scatter_item(0, 0, 0, 0, 0, 0, 3));

    // rank zero rejects every scatter
    write_reg(REG_RANK, 0);
    write_reg(REG_DEPTH, 1);
    queue_item(scatter_item(0, 0, 0, 0, 0, 0, 9));
    queue_item(flat_item(CMD_READ, 0, 0));

    // rank above the maximum is capped
    write_reg(REG_RANK, 7);
    write_reg(REG_DEPTH, 5);
    queue_item(scatter_item(3, 2, 1, 1, 1, 0, -1));
    queue_item(flat_item(CMD_READ, 95, 0));

    // a zero size empties the tensor
    write_reg(REG_DIM2, 0);
    queue_item(flat_item(CMD_READ, 0, 0));

    // random phases, the first few at the extremes of the geometry
    for (phase = 0; phase < PHASES; phase++) begin
      rank_pick = $urandom_range(1, NDIMS);
      for (i = 0; i < NDIMS; i++)
        dims_pick[i] = (i < rank_pick) ? $urandom_range(1, 9) : $urandom_range(0, 8191);
      depth_pick = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                : $urandom_range(1, rank_pick);
      case (phase)
        0: begin
          dims_pick[0] = STORE_DEPTH;
          rank_pick    = 1;
          depth_pick   = 1;
        end
        1: begin
          for (i = 0; i < NDIMS; i++) dims_pick[i] = 8191;
          rank_pick  = 5;
          depth_pick = 5;
        end
        2: begin
          dims_pick[0] = 0;
          dims_pick[1] = 5;
          dims_pick[2] = 5;
          rank_pick    = 3;
          depth_pick   = 2;
        end
        3: begin
          rank_pick  = 0;
          depth_pick = 1;
        end
        4: begin
          dims_pick  = '{3, 4, 2, 3, 2};
          rank_pick  = 7;
          depth_pick = 5;
        end
        5: begin
          dims_pick[0] = 6;
          dims_pick[1] = 5;
          dims_pick[2] = 4;
          rank_pick    = 3;
          depth_pick   = 7;
        end
        default: ;
      endcase
      set_geometry(dims_pick[0], dims_pick[1], dims_pick[2], dims_pick[3], dims_pick[4],
                   rank_pick, depth_pick);

      for (n = 0; n < PHASE_ITEMS; n++) begin
        limit = tensor_geometry();
        if (limit > STORE_DEPTH) limit = STORE_DEPTH;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          it = random_item(CMD_LOAD);
          if (limit != 0) it.flat_address = COORD_W'($urandom_range(0, int'(limit) - 1));
        end else if (pick < 55) begin
          // well-formed scatter: coordinates and offset inside the tensor
          it = random_item(CMD_SCATTER);
          it.coord0 = shaped_coord(0);
          it.coord1 = shaped_coord(1);
          it.coord2 = shaped_coord(2);
          it.coord3 = shaped_coord(3);
          it.coord4 = shaped_coord(4);
          if (depth_reg >= 1 && depth_reg <= NDIMS) begin
            span = (geo_stride[depth_reg-1] > STORE_DEPTH) ? STORE_DEPTH
                                                           : int'(geo_stride[depth_reg-1]);
            if (span != 0) it.slice_offset = COORD_W'($urandom_range(0, span - 1));
          end
        end else if (pick < 85) begin
          it = random_item(CMD_READ);
          if (written_list.size() != 0 && $urandom_range(0, 3) != 0)
            it.flat_address = written_list[$urandom_range(0, written_list.size() - 1)];
        end else if (pick < 93) begin
          it = random_item(CMD_SCATTER);
        end else if (pick < 97) begin
          it = random_item(($urandom_range(0, 1) == 1) ? CMD_LOAD : CMD_READ);
        end else begin
          it = random_item(CMD_NONE);
        end
        queue_item(it);
      end
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    mismatch_count += awaited_replies.size();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
